FILE: rtl/free_frame_stack_allocator_macros.svh
// Assertion macros for the free frame stack allocator.
// Clock clk_i and active-low reset rst_ni are assumed in scope.
`ifndef FREE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define FREE_FRAME_STACK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FFSA_ASSERT(lbl, prop, msg)
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/ffsa_pkg.sv
// Package for the free frame stack allocator: sizes, codes, beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  localparam int unsigned STACK_DEPTH = 4096;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned OFFS_W      = 12;
  localparam int unsigned FRAME_W     = ADDR_W - OFFS_W;
  localparam int unsigned SPAN_W      = FRAME_W + 1;
  localparam int unsigned ALU_W       = ADDR_W + 1;
  localparam int unsigned TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned ADDED_W     = 13;
  localparam int unsigned ADDED_MAX   = 8191;
  localparam int unsigned SAT_W       = (TOP_W > ADDED_W) ? TOP_W : ADDED_W;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REGION = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] frame_address;
    logic [ADDR_W-1:0] region_length;
    logic              region_available;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  allocated_address;
    logic [ADDED_W-1:0] frames_added;
  } out_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [FRAME_W-1:0] frame;
  } stk_ctrl_t;

  typedef struct packed {
    logic [TOP_W-1:0] top;
    logic             empty;
    logic             full;
  } stk_stat_t;

  function automatic logic [ADDED_W-1:0] sat_added(input logic [TOP_W-1:0] n);
    logic [SAT_W-1:0] w;
    w = SAT_W'(n);
    if (w > SAT_W'(ADDED_MAX)) begin
      return ADDED_W'(ADDED_MAX);
    end
    return ADDED_W'(w);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/free_frame_stack_allocator.sv
// Free frame stack allocator top level: floor register, result register,
// sequencer and stack. Depends on ffsa_pkg, ffsa_ctrl and ffsa_stack.
//
// Input channel in_valid_i / in_stall_o carries one command beat (in_i).
// Output channel out_valid_o / out_stall_i carries one result beat per command.
// Config channel cfg_valid_i / cfg_ready_o writes the memory floor; it is
// always ready; the user must see that it is written only while no command
// is in flight, as the block itself does not enforce it. Alloc and free go
// from accept straight to the done state; the result enters the output
// register from there once that register is free. Add region works out the
// bounds in five steps on the shared adder and then pushes one frame a cycle
// through the single write port of the stack memory. An empty span ends
// after four steps; an unavailable region goes straight to done like alloc.
// One command is in work at a time; in_stall_o is high until its result
// has entered the output register. If the receiver stalls with a result
// still held, the next result waits inside and input stays stalled.
// Reset empties the stack, clears the floor and drops any result.
// The stack memory needs no clearing pass: only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module free_frame_stack_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ffsa_pkg::in_t               in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output ffsa_pkg::out_t                   out_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ffsa_pkg::ADDR_W-1:0] cfg_data_i
);
  import ffsa_pkg::*;

  logic [ADDR_W-1:0]  floor_q;
  logic               out_valid_q, out_valid_d;
  out_t               out_q;
  stk_ctrl_t          stk_ctrl;
  stk_stat_t          stk_stat;
  logic [FRAME_W-1:0] rd_data;
  logic               res_free, res_valid;
  out_t               res;

  assign cfg_ready_o = 1'b1;
  assign res_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      floor_q <= cfg_data_i;
    end
  end

  ffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .floor_i     (floor_q),
    .stat_i      (stk_stat),
    .rd_data_i   (rd_data),
    .stk_o       (stk_ctrl),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ffsa_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stk_ctrl),
    .stat_o    (stk_stat),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: rtl/ffsa_stack.sv
// Free frame stack: frame number memory and stack pointer.
// Depends on ffsa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "free_frame_stack_allocator_macros.svh"

module ffsa_stack (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ffsa_pkg::stk_ctrl_t         ctrl_i,
  output ffsa_pkg::stk_stat_t              stat_o,
  output logic [ffsa_pkg::FRAME_W-1:0]     rd_data_o
);
  import ffsa_pkg::*;

  logic [FRAME_W-1:0] mem [STACK_DEPTH];
  logic [TOP_W-1:0]   top_q, top_d;
  logic [FRAME_W-1:0] rd_data_q;
  logic [TOP_W-1:0]   top_dec;
  logic [IDX_W-1:0]   wr_idx, rd_idx;

  assign top_dec = top_q - TOP_W'(1);
  assign wr_idx  = top_q[IDX_W-1:0];
  assign rd_idx  = top_dec[IDX_W-1:0];

  always_comb begin
    top_d = top_q;
    if (ctrl_i.push) begin
      top_d = top_q + TOP_W'(1);
    end else if (ctrl_i.pop) begin
      top_d = top_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_idx] <= ctrl_i.frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  assign stat_o.top   = top_q;
  assign stat_o.empty = (top_q == '0);
  assign stat_o.full  = (top_q == TOP_W'(STACK_DEPTH));
  assign rd_data_o    = rd_data_q;

  `FFSA_ASSERT(a_push_room, ctrl_i.push |-> (top_q < TOP_W'(STACK_DEPTH)), "push into full stack")
  `FFSA_ASSERT(a_pop_data, ctrl_i.pop |-> (top_q != '0), "pop from empty stack")
  `FFSA_ASSERT(a_one_op, !(ctrl_i.push && ctrl_i.pop), "push and pop together")
  `FFSA_ASSERT(a_top_hold, (!ctrl_i.push && !ctrl_i.pop) |=> $stable(top_q), "pointer moved")

endmodule

`default_nettype wire

FILE: rtl/ffsa_ctrl.sv
// Command sequencer with the shared 49-bit add/subtract unit.
// Works out region bounds step by step and pushes one frame a cycle.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffsa_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ffsa_pkg::in_t               in_i,
  input  wire logic [ffsa_pkg::ADDR_W-1:0] floor_i,
  input  wire ffsa_pkg::stk_stat_t         stat_i,
  input  wire logic [ffsa_pkg::FRAME_W-1:0] rd_data_i,
  output ffsa_pkg::stk_ctrl_t              stk_o,
  input  wire logic                        res_free_i,
  output logic                             res_valid_o,
  output ffsa_pkg::out_t                   res_o
);
  import ffsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_END   = 8'b0000_0010,
    S_BASE  = 8'b0000_0100,
    S_FLOOR = 8'b0000_1000,
    S_SPAN  = 8'b0001_0000,
    S_ROOM  = 8'b0010_0000,
    S_FILL  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ADDR_W-1:0]  len_q, len_d;
  logic [SPAN_W-1:0]  end_q, end_d;
  logic [SPAN_W-1:0]  beg_q, beg_d;
  logic [SPAN_W-1:0]  total_q, total_d;
  logic [TOP_W-1:0]   n_q, n_d;
  logic [TOP_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  status_e            st_q, st_d;
  logic [ADDED_W-1:0] added_q, added_d;
  logic               alloc_q, alloc_d;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
  logic               alu_sub, alu_cin;
  logic               accept;
  logic [TOP_W-1:0]   room, cnt_inc;
  logic [SPAN_W-1:0]  alu_span;

  // shared unit
  assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_cin);
  assign alu_span = alu_sum[SPAN_W-1:0];
  assign room     = alu_sum[TOP_W-1:0];
  assign cnt_inc  = cnt_q + TOP_W'(1);

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    alu_cin = 1'b0;
    unique case (state_q)
      S_END: begin
        alu_a = ALU_W'(addr_q);
        alu_b = ALU_W'(len_q);
      end
      S_BASE: begin
        alu_a   = ALU_W'(addr_q[ADDR_W-1:OFFS_W]);
        alu_cin = |addr_q[OFFS_W-1:0];
      end
      S_FLOOR: begin
        alu_a   = ALU_W'(floor_i[ADDR_W-1:OFFS_W]);
        alu_cin = |floor_i[OFFS_W-1:0];
      end
      S_SPAN: begin
        alu_a   = ALU_W'(end_q);
        alu_b   = ALU_W'(beg_q);
        alu_sub = 1'b1;
        alu_cin = 1'b1;
      end
      S_ROOM: begin
        alu_a   = ALU_W'(STACK_DEPTH);
        alu_b   = ALU_W'(stat_i.top);
        alu_sub = 1'b1;
        alu_cin = 1'b1;
      end
      S_FILL: begin
        alu_a   = ALU_W'(beg_q);
        alu_cin = 1'b1;
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    len_d     = len_q;
    end_d     = end_q;
    beg_d     = beg_q;
    total_d   = total_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    st_d      = st_q;
    added_d   = added_q;
    alloc_d   = alloc_q;
    stk_o     = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d  = in_i.frame_address;
          len_d   = in_i.region_length;
          st_d    = ST_OK;
          added_d = '0;
          alloc_d = 1'b0;
          state_d = S_DONE;
          case (in_i.command)
            CMD_ALLOC: begin
              if (stat_i.empty) begin
                st_d = ST_OOM;
              end else begin
                stk_o.pop = 1'b1;
                alloc_d   = 1'b1;
              end
            end
            CMD_FREE: begin
              if (stat_i.full) begin
                st_d = ST_FULL;
              end else begin
                stk_o.push  = 1'b1;
                stk_o.frame = in_i.frame_address[ADDR_W-1:OFFS_W];
                added_d     = ADDED_W'(1);
              end
            end
            CMD_REGION: begin
              if (in_i.region_available) begin
                state_d = S_END;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_END: begin
        // end clipped to the top of the address space
        if (alu_sum[ALU_W-1]) begin
          end_d = {1'b1, {FRAME_W{1'b0}}};
        end else begin
          end_d = {1'b0, alu_sum[ADDR_W-1:OFFS_W]};
        end
        state_d = S_BASE;
      end
      S_BASE: begin
        beg_d   = alu_span;
        state_d = S_FLOOR;
      end
      S_FLOOR: begin
        if (alu_span > beg_q) begin
          beg_d = alu_span;
        end
        state_d = S_SPAN;
      end
      S_SPAN: begin
        if (alu_sum[ALU_W-1] || (alu_sum == '0)) begin
          state_d = S_DONE;
        end else begin
          total_d = alu_span;
          state_d = S_ROOM;
        end
      end
      S_ROOM: begin
        cnt_d = '0;
        if (total_q < SPAN_W'(room)) begin
          n_d   = TOP_W'(total_q);
          ovf_d = 1'b0;
        end else begin
          n_d   = room;
          ovf_d = (total_q != SPAN_W'(room));
        end
        if (room == '0) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        stk_o.push  = 1'b1;
        stk_o.frame = beg_q[FRAME_W-1:0];
        beg_d       = alu_span;
        cnt_d       = cnt_inc;
        if (cnt_inc == n_q) begin
          st_d    = ovf_q ? ST_FULL : ST_OK;
          added_d = sat_added(n_q);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.status            = st_q;
    res_o.allocated_address = alloc_q ? {rd_data_i, {OFFS_W{1'b0}}} : '0;
    res_o.frames_added      = added_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    len_q   <= len_d;
    end_q   <= end_d;
    beg_q   <= beg_d;
    total_q <= total_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    ovf_q   <= ovf_d;
    st_q    <= st_d;
    added_q <= added_d;
    alloc_q <= alloc_d;
  end

endmodule

`default_nettype wire

FILE: test/free_frame_stack_allocator_test.sv
// Self-checking testbench for free_frame_stack_allocator: directed and random
// alloc/free/region beats, checked against a behavioural stack model.
// Depends on ffsa_pkg and the RTL of free_frame_stack_allocator.
`timescale 1ns / 1ps

module free_frame_stack_allocator_test;
  import ffsa_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [63:0] ADDR_SPAN   = 64'h1_0000_0000_0000;
  localparam logic [63:0] OFFS_MASK   = 64'hFFF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 40000;

  class frame_stack_book;
    logic [FRAME_W-1:0] frames [STACK_DEPTH];
    int unsigned        used;
    logic [ADDR_W-1:0]  floor_reg;
    out_t               pending [$];
    int unsigned        errors, checked, oom_seen, full_seen, region_frames;
    int unsigned        cmd_seen [4];

    function logic [63:0] align_frame(logic [63:0] a);
      return (a + OFFS_MASK) & ~OFFS_MASK;
    endfunction

    function void note_cmd(in_t c);
      out_t        want;
      logic [63:0] lo, hi, total, n;
      want = '0;
      cmd_seen[c.command]++;
      case (c.command)
        CMD_ALLOC: begin
          if (used == 0) begin
            want.status = ST_OOM;
          end else begin
            used--;
            want.allocated_address = {frames[used], {OFFS_W{1'b0}}};
          end
        end
        CMD_FREE: begin
          if (used == STACK_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            frames[used] = c.frame_address[ADDR_W-1:OFFS_W];
            used++;
            want.frames_added = ADDED_W'(1);
          end
        end
        CMD_REGION: begin
          if (c.region_available) begin
            lo = align_frame({16'h0, floor_reg});
            if ({16'h0, c.frame_address} > lo) begin
              lo = {16'h0, c.frame_address};
            end
            lo = align_frame(lo);
            hi = ({16'h0, c.frame_address} + {16'h0, c.region_length}) & ~OFFS_MASK;
            if (hi > ADDR_SPAN) begin
              hi = ADDR_SPAN;
            end
            if (hi > lo) begin
              total = (hi - lo) >> OFFS_W;
              n = (total < STACK_DEPTH - used) ? total : STACK_DEPTH - used;
              for (int k = 0; k < n; k++) begin
                frames[used] = FRAME_W'((lo >> OFFS_W) + k);
                used++;
              end
              if (n < total) begin
                want.status = ST_FULL;
              end
              want.frames_added = (n > ADDED_MAX) ? ADDED_W'(ADDED_MAX) : ADDED_W'(n);
              region_frames += 32'(n);
            end
          end
        end
        default: ;
      endcase
      pending.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.status == ST_OOM) oom_seen++;
      if (want.status == ST_FULL) full_seen++;
      if (got.status !== want.status) begin
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  checked, got.status, want.status));
      end
      if (got.allocated_address !== want.allocated_address) begin
        report_mismatch($sformatf("result %0d address %h, want %h",
                                  checked, got.allocated_address, want.allocated_address));
      end
      if (got.frames_added !== want.frames_added) begin
        report_mismatch($sformatf("result %0d frames_added %0d, want %0d",
                                  checked, got.frames_added, want.frames_added));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_beat = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_beat;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  frame_stack_book book = new;
  int unsigned     sent = 0;
  bit              hold_req = 1'b0;

  free_frame_stack_allocator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic in_t make_cmd(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] len, logic avail);
    in_t c;
    c.command          = cmd;
    c.frame_address    = addr;
    c.region_length    = len;
    c.region_available = avail;
    return c;
  endfunction

  // Mostly small regions around the floor; a few near the top of memory and
  // a few fully random ones, which usually fill the stack.
  function automatic in_t random_cmd(logic [ADDR_W-1:0] floor_now);
    in_t               c;
    int unsigned       pick;
    logic [ADDR_W-1:0] near;
    c = make_cmd(CMD_ALLOC, rand48(), rand48(), 1'($urandom));
    near = {floor_now[ADDR_W-1:OFFS_W], {OFFS_W{1'b0}}} - ADDR_W'('h4000)
           + ADDR_W'($urandom_range(0, 'h8000));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.command = CMD_ALLOC;
    end else if (pick < 72) begin
      c.command = CMD_FREE;
    end else if (pick < 95) begin
      c.command = CMD_REGION;
      c.region_available = $urandom_range(0, 9) != 0;
      pick = $urandom_range(0, 99);
      if (pick >= 3) begin
        c.frame_address = (pick < 8) ? {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 'h8000))
                                     : near;
        if ($urandom_range(0, 3) != 0) begin
          c.frame_address[OFFS_W-1:0] = '0;
        end
        c.region_length = ADDR_W'($urandom_range(0, 12)) << OFFS_W;
        if ($urandom_range(0, 2) == 0) begin
          c.region_length[OFFS_W-1:0] = OFFS_W'($urandom);
        end
      end
    end else begin
      c.command = CMD_UNUSED;
    end
    return c;
  endfunction

  task automatic send_cmd(input in_t beat);
    int unsigned gap;
    gap = ((sent % 160) < 40) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    book.note_cmd(beat);
    sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_floor(input logic [ADDR_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    book.floor_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per beat, quiet stretches, and one long hold
  // on request so the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= hold_left != 0;
      if (hold_left != 0) hold_left--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        book.check_result(out_beat);
        hold_left = ((book.checked % 256) < 64) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
          || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: %0d cycles without a beat, %0d results outstanding",
             STALL_LIMIT, book.pending.size());
    $display("free_frame_stack_allocator_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] floors [4];
    int unsigned       counts [4];
    floors[0] = '0;
    floors[1] = {ADDR_W{1'b1}};
    floors[2] = rand48();
    floors[3] = 48'h0000_0008_0800;
    counts[0] = 400;
    counts[1] = 150;
    counts[2] = 500;
    counts[3] = 500;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: floor not on a frame boundary, rounds up to 0x2000.
    write_floor(48'h0000_0000_1001);
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_FREE, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_FREE, {ADDR_W{1'b1}}, '0, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, {ADDR_W{1'b1}}, {ADDR_W{1'b1}}, 1'b1));
    send_cmd(make_cmd(CMD_REGION, 48'h2000, 48'h10000, 1'b0));
    send_cmd(make_cmd(CMD_REGION, 48'h4000, '0, 1'b1));
    send_cmd(make_cmd(CMD_REGION, '0, 48'h4000, 1'b1));
    send_cmd(make_cmd(CMD_REGION, 48'h5000, 48'h800, 1'b1));
    send_cmd(make_cmd(CMD_REGION, 48'h1_0001, 48'h3000, 1'b1));
    send_cmd(make_cmd(CMD_REGION, 48'hFFFF_FFFF_E000, {ADDR_W{1'b1}}, 1'b1));
    send_cmd(make_cmd(CMD_UNUSED, {ADDR_W{1'b1}}, {ADDR_W{1'b1}}, 1'b1));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_FREE, 48'h1234_5678_9ABC, '0, 1'b0));
    send_cmd(make_cmd(CMD_REGION, 48'h10_0000, ADDR_W'((STACK_DEPTH + 1) << OFFS_W), 1'b1));
    send_cmd(make_cmd(CMD_FREE, 48'h7000, '0, 1'b0));
    send_cmd(make_cmd(CMD_REGION, '0, 48'h10000, 1'b1));
    send_cmd(make_cmd(CMD_UNUSED, '0, '0, 1'b0));
    send_cmd(make_cmd(CMD_ALLOC, '0, '0, 1'b0));

    for (int p = 0; p < 4; p++) begin
      write_floor(floors[p]);
      repeat (counts[p]) begin
        if (sent == 700 || sent == 1300) begin
          hold_req = 1'b1;
        end
        send_cmd(random_cmd(book.floor_reg));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Ran %0d beats: %0d alloc, %0d free, %0d region, %0d unused code, five floors",
             sent, book.cmd_seen[CMD_ALLOC], book.cmd_seen[CMD_FREE],
             book.cmd_seen[CMD_REGION], book.cmd_seen[CMD_UNUSED]);
    $display("Checked %0d results: %0d out of memory, %0d stack full, %0d region frames, %0d errors",
             book.checked, book.oom_seen, book.full_seen, book.region_frames, book.errors);
    if (book.errors == 0) begin
      $display("free_frame_stack_allocator_test OK");
    end else begin
      $display("free_frame_stack_allocator_test NOT OK");
    end
    $finish;
  end

endmodule
